### hdl/rkm_pkg.sv
// Package for the ring keyword matcher: register map, keyword types and field widths.
// No dependencies; every other file of the block imports it.
package rkm_pkg;

    // Field widths fixed by the register map and the word format
    localparam int SLOT_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 2;
    localparam int COUNT_W    = 2;
    localparam int KW_BYTES_W = 40;
    localparam int KW_LEN_W   = 3;
    localparam int KW_SLOTS   = 3;
    localparam int KW_REG_BYTES = KW_BYTES_W / BYTE_W;

    // Configuration port geometry: 64-bit registers at 8-byte strides
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REG_IDX_W = 3;
    localparam int REG_IDX_LSB = 3;

    // Register index within the map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_KEYWORD_COUNT  = 3'd0,
        REG_KW_ZERO_BYTES  = 3'd1,
        REG_KW_ZERO_LENGTH = 3'd2,
        REG_KW_ONE_BYTES   = 3'd3,
        REG_KW_ONE_LENGTH  = 3'd4,
        REG_KW_TWO_BYTES   = 3'd5,
        REG_KW_TWO_LENGTH  = 3'd6
    } t_reg_index;

    // Operation carried by an input word
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_CHECK = 1'b1
    } t_operation;

    // Code returned when nothing matched, or for a store
    localparam logic [CODE_W-1:0] NO_MATCH = '0;

    // One keyword: first byte in the low byte
    typedef struct packed {
        logic [KW_BYTES_W-1:0] bytes;
        logic [KW_LEN_W-1:0]   length;
    } t_keyword;

    // Match settings handed from the register file to the matcher
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        t_keyword [KW_SLOTS-1:0]      keywords;
    } t_match_cfg;

endpackage

### hdl/rkm_cfg_regs.sv
// APB-style register file for the keyword count and the three keywords.
// Depends on rkm_pkg.
module rkm_cfg_regs
    import rkm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_match_cfg         o_cfg
);

    logic [COUNT_W-1:0]    r_count;
    t_keyword [KW_SLOTS-1:0] r_keywords;
    logic                  wr_en;
    t_reg_index            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_index'(paddr[REG_IDX_LSB +: REG_IDX_W]);

    // Write a register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_keywords <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEYWORD_COUNT:  r_count              <= pwdata[COUNT_W-1:0];
                REG_KW_ZERO_BYTES:  r_keywords[0].bytes  <= pwdata[KW_BYTES_W-1:0];
                REG_KW_ZERO_LENGTH: r_keywords[0].length <= pwdata[KW_LEN_W-1:0];
                REG_KW_ONE_BYTES:   r_keywords[1].bytes  <= pwdata[KW_BYTES_W-1:0];
                REG_KW_ONE_LENGTH:  r_keywords[1].length <= pwdata[KW_LEN_W-1:0];
                REG_KW_TWO_BYTES:   r_keywords[2].bytes  <= pwdata[KW_BYTES_W-1:0];
                REG_KW_TWO_LENGTH:  r_keywords[2].length <= pwdata[KW_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero-extended
    always_comb begin
        unique case (reg_idx)
            REG_KEYWORD_COUNT:  prdata = PDATA_W'(r_count);
            REG_KW_ZERO_BYTES:  prdata = PDATA_W'(r_keywords[0].bytes);
            REG_KW_ZERO_LENGTH: prdata = PDATA_W'(r_keywords[0].length);
            REG_KW_ONE_BYTES:   prdata = PDATA_W'(r_keywords[1].bytes);
            REG_KW_ONE_LENGTH:  prdata = PDATA_W'(r_keywords[1].length);
            REG_KW_TWO_BYTES:   prdata = PDATA_W'(r_keywords[2].bytes);
            REG_KW_TWO_LENGTH:  prdata = PDATA_W'(r_keywords[2].length);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.count    = r_count;
    assign o_cfg.keywords = r_keywords;

endmodule

### hdl/rkm_matcher.sv
// Parallel keyword search over every rotation of the key ring.
// Depends on rkm_pkg; purely combinational.
module rkm_matcher
    import rkm_pkg::*;
#(
    parameter int RING_SIZE         = 16,
    parameter int MAX_KEYWORD_BYTES = 5,
    parameter int NUM_KEYWORDS      = 3
) (
    input  logic [BYTE_W-1:0] i_ring [RING_SIZE],
    input  t_match_cfg        i_cfg,
    output logic [CODE_W-1:0] o_code
);

    localparam int LEN_CMP_W = KW_LEN_W + 1;

    logic [NUM_KEYWORDS-1:0] kw_hit;

    // Compare each keyword at each start position, wrapping around the ring
    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
        logic [RING_SIZE-1:0] start_hit;

        for (genvar s = 0; s < RING_SIZE; s++) begin : g_start
            logic [MAX_KEYWORD_BYTES-1:0] byte_ok;

            for (genvar i = 0; i < MAX_KEYWORD_BYTES; i++) begin : g_byte
                localparam int POS = (s + i) % RING_SIZE;
                logic [BYTE_W-1:0] kw_byte;
                logic              needed;

                if (i < KW_REG_BYTES) begin : g_stored
                    assign kw_byte = i_cfg.keywords[k].bytes[BYTE_W*i +: BYTE_W];
                end else begin : g_blank
                    assign kw_byte = '0;
                end

                // Byte only counts when it lies inside the keyword length
                assign needed = {1'b0, i_cfg.keywords[k].length} > LEN_CMP_W'(i);
                assign byte_ok[i] = !needed || (kw_byte == i_ring[POS]);
            end

            assign start_hit[s] = &byte_ok;
        end

        assign kw_hit[k] = |start_hit;
    end

    // Take the first active keyword that hit
    always_comb begin
        logic found;
        found  = 1'b0;
        o_code = NO_MATCH;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (!found && kw_hit[k] && (COUNT_W'(k) < i_cfg.count)) begin
                found  = 1'b1;
                o_code = CODE_W'(k + 1);
            end
        end
    end

endmodule

### hdl/ring_keyword_matcher.sv
// Top level of the ring keyword matcher: input register, key ring, result register.
// Depends on rkm_pkg, rkm_cfg_regs and rkm_matcher.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+----------------------------------
//   input    | i_in_valid / o_in_ready     | i_operation, i_slot, i_key_byte
//   result   | o_out_valid / i_out_ready   | o_match_code
//   config   | psel, penable, pwrite/pready| paddr, pwdata, prdata
//
// One word is accepted per cycle while o_in_ready is high; an accepted word is held in
// the input register and then loaded into the result register, which raises o_out_valid.
// The search over all ring rotations and keywords is one combinational pass between
// the input register and the result register, which also writes or clears the ring.
// A stalled result holds the input register, and o_in_ready drops while both are full and the result is stalled.
// Synchronous active-low reset clears the ring, the configuration registers and both valid flags.
module ring_keyword_matcher
    import rkm_pkg::*;
#(
    parameter int RING_SIZE         = 16,
    parameter int MAX_KEYWORD_BYTES = 5,
    parameter int NUM_KEYWORDS      = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [BYTE_W-1:0]  i_key_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CODE_W-1:0]  o_match_code,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W  = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int CALC_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam int FOLD_STEPS = (1 << SLOT_W) / RING_SIZE + 1;

    // Fold a slot into the ring by repeated subtraction
    function automatic logic [IDX_W-1:0] ring_index(input logic [SLOT_W-1:0] slot);
        logic [CALC_W-1:0] v;
        v = CALC_W'(slot);
        for (int j = 0; j < FOLD_STEPS; j++) begin
            if (v >= CALC_W'(RING_SIZE)) begin
                v = v - CALC_W'(RING_SIZE);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    t_match_cfg        cfg;
    logic [CODE_W-1:0] code;
    logic              advance;

    logic              r_in_valid;
    logic              r_operation;
    logic [SLOT_W-1:0] r_slot;
    logic [BYTE_W-1:0] r_key_byte;
    logic [BYTE_W-1:0] r_key_ring [RING_SIZE];
    logic              r_out_valid;
    logic [CODE_W-1:0] r_match_code;
    logic              n_out_valid;
    logic              n_in_valid;

    rkm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rkm_matcher #(
        .RING_SIZE         (RING_SIZE),
        .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES),
        .NUM_KEYWORDS      (NUM_KEYWORDS)
    ) u_matcher (
        .i_ring (r_key_ring),
        .i_cfg  (cfg),
        .o_code (code)
    );

    // Move the held word forward when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_operation <= i_operation;
            r_slot      <= i_slot;
            r_key_byte  <= i_key_byte;
        end
    end

    // Write a key byte on a store, clear the whole ring on a hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < RING_SIZE; p++) begin
                r_key_ring[p] <= '0;
            end
        end else if (advance) begin
            if (r_operation == OP_STORE) begin
                r_key_ring[ring_index(r_slot)] <= r_key_byte;
            end else if (code != NO_MATCH) begin
                for (int p = 0; p < RING_SIZE; p++) begin
                    r_key_ring[p] <= '0;
                end
            end
        end
    end

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_match_code <= (r_operation == OP_STORE) ? NO_MATCH : code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_match_code = r_match_code;

endmodule
